// ===== rtl/q2e_pkg.sv =====
// shared constants, payload types and helper functions of the quaternion to euler converter
package q2e_pkg;

  localparam int COMPONENT_BITS  = 16;
  localparam int ANGLE_FRAC_BITS = 7;

  localparam int PITCH_W = ANGLE_FRAC_BITS + 8;
  localparam int EULER_W = ANGLE_FRAC_BITS + 9;

  // internal component format is q1.15
  localparam int Q_W      = 16;
  localparam int SCALE_UP = (COMPONENT_BITS <= Q_W) ? (Q_W - COMPONENT_BITS) : 0;
  localparam int SCALE_DN = (COMPONENT_BITS > Q_W) ? (COMPONENT_BITS - Q_W) : 0;

  localparam int PROD_W = 2 * Q_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int PAIR_W = 31;
  localparam int RAD_W  = 2 * PAIR_W;
  localparam int ROOT_W = PAIR_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int THR_W  = 33;
  localparam int CFG_W  = 16;

  localparam logic [CFG_W-1:0] MIN_LENGTH_RST = 16'd1;
  localparam logic [THR_W-1:0] THR_RST        = 33'd4;

  // cordic datapath
  localparam int CIN_W        = SUM_W + 1;
  localparam int XW           = 45;
  localparam int MW           = 41;
  localparam int NORM_MSB     = 40;
  localparam int ZW           = 27;
  localparam int PRE_STEPS    = 6;
  localparam int CORDIC_STEPS = 20;
  localparam int NSTG         = 1 + PRE_STEPS + CORDIC_STEPS;
  localparam int LANES        = 3;
  localparam int LANE_PITCH   = 0;
  localparam int LANE_YAW     = 1;
  localparam int LANE_ROLL    = 2;

  localparam logic signed [ZW-1:0] DEG90  = 27'sd5898240;
  localparam logic signed [ZW-1:0] DEG180 = 27'sd11796480;

  // atan(2^-i) in degrees with 16 fraction bits
  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945, 27'sd234379,
    27'sd117304,  27'sd58666,   27'sd29335,  27'sd14668,  27'sd7334,
    27'sd3667,    27'sd1833,    27'sd917,    27'sd458,    27'sd229,
    27'sd115,     27'sd57,      27'sd29,     27'sd14,     27'sd7
  };

  // output rounding
  localparam int RW     = ZW + 1;
  localparam int RND_SH = 16 - ANGLE_FRAC_BITS;
  localparam logic signed [RW-1:0] RND_HALF =
    (RND_SH > 0) ? (RW'(1) << (RND_SH - 1)) : RW'(0);
  localparam logic signed [RW-1:0] LIM_PITCH = RW'(90) <<< ANGLE_FRAC_BITS;
  localparam logic signed [RW-1:0] LIM_EULER = RW'(180) <<< ANGLE_FRAC_BITS;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] quat_x;
    logic signed [COMPONENT_BITS-1:0] quat_y;
    logic signed [COMPONENT_BITS-1:0] quat_z;
    logic signed [COMPONENT_BITS-1:0] quat_w;
  } q2e_in_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch_deg;
    logic signed [EULER_W-1:0] yaw_deg;
    logic signed [EULER_W-1:0] roll_deg;
    logic                      degenerate;
    logic                      gimbal_clamped;
  } q2e_out_t;

  typedef struct packed {
    logic degenerate;
    logic gimbal;
  } q2e_flags_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] num;
    logic signed [SUM_W-1:0] yaw_y;
    logic signed [SUM_W-1:0] yaw_x;
    logic signed [SUM_W-1:0] roll_y;
    logic signed [SUM_W-1:0] roll_x;
    q2e_flags_t              flags;
  } q2e_side_t;

  function automatic logic signed [Q_W-1:0] scale_comp(
    input logic signed [COMPONENT_BITS-1:0] v
  );
    logic signed [63:0] wide;
    wide = 64'(v);
    wide = (wide <<< SCALE_UP) >>> SCALE_DN;
    return wide[Q_W-1:0];
  endfunction

  function automatic logic signed [RW-1:0] round_angle(
    input logic signed [ZW-1:0] z,
    input logic signed [RW-1:0] lim
  );
    logic signed [RW-1:0] q;
    q = (RW'(z) + RND_HALF) >>> RND_SH;
    if (q > lim) begin
      q = lim;
    end
    if (q < -lim) begin
      q = -lim;
    end
    return q;
  endfunction

endpackage

// ===== rtl/quaternion_to_euler_core.sv =====
// quaternion to euler angle converter, top level
// Takes one quaternion per clock and returns pitch, yaw and roll in degrees with
// ANGLE_FRAC_BITS fraction bits. The block is a single stalling pipeline of 4 front-end
// stages, the 31-stage square root on the pitch path, 27 cordic stages, one rounding
// stage and the output register, and one transaction is taken every cycle while the
// output side keeps taking results. A two-entry output buffer decouples the sides,
// so in_ready_o only drops once that buffer is full. cfg_ready_o is always high;
// min_length must only be written while no transaction is in flight.
module quaternion_to_euler_core import q2e_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  q2e_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output q2e_out_t         out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [CFG_W-1:0]        min_length_q;
  logic [CFG_W:0]          ml_inc;
  logic [THR_W-1:0]        thr_d, thr_q;
  logic                    en;

  logic                    fe_valid;
  logic [RAD_W-1:0]        fe_rad;
  q2e_side_t               fe_side;

  logic                    sq_valid;
  logic [ROOT_W-1:0]       sq_root;
  q2e_side_t               sq_side;

  logic signed [CIN_W-1:0] cy [LANES];
  logic signed [CIN_W-1:0] cx [LANES];
  logic                    cd_valid;
  logic signed [ZW-1:0]    cd_z [LANES];
  q2e_flags_t              cd_flags;

  logic signed [RW-1:0]    pitch_r, yaw_r, roll_r;
  q2e_out_t                r_d, r_q, out_q, skid_q;
  logic                    r_vld_q, out_vld_q, skid_vld_q;
  logic                    take, push;

  // configuration: length test is s < (min_length + 1)^2
  assign cfg_ready_o = 1'b1;
  assign ml_inc      = (CFG_W + 1)'(min_length_q) + (CFG_W + 1)'(1);
  assign thr_d       = THR_W'(ml_inc) * THR_W'(ml_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= MIN_LENGTH_RST;
      thr_q        <= THR_RST;
    end else begin
      if (cfg_valid_i) begin
        min_length_q <= cfg_data_i;
      end
      thr_q <= thr_d;
    end
  end

  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  q2e_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .thr_i   (thr_q),
    .valid_o (fe_valid),
    .rad_o   (fe_rad),
    .side_o  (fe_side)
  );

  q2e_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fe_valid),
    .rad_i   (fe_rad),
    .side_i  (fe_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // gimbal lock feeds x = 0 so the pitch lane lands on plus or minus 90
  always_comb begin
    cy[LANE_PITCH] = CIN_W'(sq_side.num);
    cx[LANE_PITCH] = sq_side.flags.gimbal ? CIN_W'(0) : CIN_W'(sq_root);
    cy[LANE_YAW]   = CIN_W'(sq_side.yaw_y);
    cx[LANE_YAW]   = CIN_W'(sq_side.yaw_x);
    cy[LANE_ROLL]  = CIN_W'(sq_side.roll_y);
    cx[LANE_ROLL]  = CIN_W'(sq_side.roll_x);
  end

  q2e_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .y_i     (cy),
    .x_i     (cx),
    .flags_i (sq_side.flags),
    .valid_o (cd_valid),
    .z_o     (cd_z),
    .flags_o (cd_flags)
  );

  // rounding stage
  always_comb begin
    pitch_r = round_angle(cd_z[LANE_PITCH], LIM_PITCH);
    yaw_r   = round_angle(cd_z[LANE_YAW], LIM_EULER);
    roll_r  = round_angle(cd_z[LANE_ROLL], LIM_EULER);
    if (cd_flags.degenerate) begin
      r_d.pitch_deg      = '0;
      r_d.yaw_deg        = '0;
      r_d.roll_deg       = '0;
      r_d.degenerate     = 1'b1;
      r_d.gimbal_clamped = 1'b0;
    end else begin
      r_d.pitch_deg      = PITCH_W'(pitch_r);
      r_d.yaw_deg        = EULER_W'(yaw_r);
      r_d.roll_deg       = EULER_W'(roll_r);
      r_d.degenerate     = 1'b0;
      r_d.gimbal_clamped = cd_flags.gimbal;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else if (en) begin
      r_vld_q <= cd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q <= r_d;
    end
  end

  // output register with skid entry
  assign take = out_vld_q && out_ready_i;
  assign push = r_vld_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (take) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end
      end else if (!out_vld_q || take) begin
        out_vld_q <= push;
      end else if (push) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || take) begin
      if (push) begin
        out_q <= r_q;
      end
    end else if (push) begin
      skid_q <= r_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/q2e_front.sv =====
// front end: component products, sums, gimbal and length tests, radicand product
module q2e_front import q2e_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  q2e_in_t                 data_i,
  input  logic [THR_W-1:0]        thr_i,
  output logic                    valid_o,
  output logic [RAD_W-1:0]        rad_o,
  output q2e_side_t               side_o
);

  logic signed [Q_W-1:0] qx, qy, qz, qw;
  logic signed [PROD_W-1:0] xx_q, yy_q, zz_q, ww_q, wx_q, yz_q, wy_q, zx_q, wz_q, xy_q;
  logic signed [SUM_W-1:0]  s_d, t_d, yaw_y_d, yaw_x_d, roll_y_d, roll_x_d;
  logic signed [SUM_W-1:0]  s_q, t_q, yaw_y_q, yaw_x_q, roll_y_q, roll_x_q;
  logic signed [SUM_W-1:0]  at;
  logic signed [SUM_W:0]    pa, pb;
  logic                     fit;
  logic [PAIR_W-1:0]        pa_d, pb_d, pa_q, pb_q;
  q2e_side_t                side_d, side_q, side4_q;
  logic [RAD_W-1:0]         rad_q;
  logic                     v1_q, v2_q, v3_q, v4_q;

  assign qx = scale_comp(data_i.quat_x);
  assign qy = scale_comp(data_i.quat_y);
  assign qz = scale_comp(data_i.quat_z);
  assign qw = scale_comp(data_i.quat_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= PROD_W'(qx) * PROD_W'(qx);
      yy_q <= PROD_W'(qy) * PROD_W'(qy);
      zz_q <= PROD_W'(qz) * PROD_W'(qz);
      ww_q <= PROD_W'(qw) * PROD_W'(qw);
      wx_q <= PROD_W'(qw) * PROD_W'(qx);
      yz_q <= PROD_W'(qy) * PROD_W'(qz);
      wy_q <= PROD_W'(qw) * PROD_W'(qy);
      zx_q <= PROD_W'(qz) * PROD_W'(qx);
      wz_q <= PROD_W'(qw) * PROD_W'(qz);
      xy_q <= PROD_W'(qx) * PROD_W'(qy);
    end
  end

  // stage 2: sums
  always_comb begin
    s_d      = SUM_W'(xx_q) + SUM_W'(yy_q) + SUM_W'(zz_q) + SUM_W'(ww_q);
    t_d      = (SUM_W'(wx_q) - SUM_W'(yz_q)) <<< 1;
    yaw_y_d  = (SUM_W'(wy_q) + SUM_W'(zx_q)) <<< 1;
    yaw_x_d  = SUM_W'(zz_q) + SUM_W'(ww_q) - SUM_W'(xx_q) - SUM_W'(yy_q);
    roll_y_d = (SUM_W'(wz_q) + SUM_W'(xy_q)) <<< 1;
    roll_x_d = SUM_W'(yy_q) + SUM_W'(ww_q) - SUM_W'(xx_q) - SUM_W'(zz_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q      <= s_d;
      t_q      <= t_d;
      yaw_y_q  <= yaw_y_d;
      yaw_x_q  <= yaw_x_d;
      roll_y_q <= roll_y_d;
      roll_x_q <= roll_x_d;
    end
  end

  // stage 3: gimbal test, length test, fit the pair into the multiplier
  always_comb begin
    at  = (t_q < 0) ? -t_q : t_q;
    pa  = (SUM_W + 1)'(s_q) + (SUM_W + 1)'(t_q);
    pb  = (SUM_W + 1)'(s_q) - (SUM_W + 1)'(t_q);
    fit = ((pa >>> PAIR_W) != 0) || ((pb >>> PAIR_W) != 0);
    pa_d = fit ? PAIR_W'(pa >>> 2) : PAIR_W'(pa);
    pb_d = fit ? PAIR_W'(pb >>> 2) : PAIR_W'(pb);
    side_d.flags.gimbal     = (at >= s_q);
    side_d.flags.degenerate = ($unsigned(s_q) < {1'b0, thr_i});
    // gimbal keeps the raw term so its sign survives
    side_d.num    = (fit && !side_d.flags.gimbal) ? (t_q >>> 2) : t_q;
    side_d.yaw_y  = yaw_y_q;
    side_d.yaw_x  = yaw_x_q;
    side_d.roll_y = roll_y_q;
    side_d.roll_x = roll_x_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      side_q <= side_d;
    end
  end

  // stage 4: (s+t)(s-t)
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q   <= RAD_W'(pa_q) * RAD_W'(pb_q);
      side4_q <= side_q;
    end
  end

  assign valid_o = v4_q;
  assign rad_o   = rad_q;
  assign side_o  = side4_q;

endmodule

// ===== rtl/q2e_sqrt.sv =====
// pipelined integer square root, one result bit per stage, side data carried along
module q2e_sqrt import q2e_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [RAD_W-1:0]    rad_i,
  input  q2e_side_t           side_i,
  output logic                valid_o,
  output logic [ROOT_W-1:0]   root_o,
  output q2e_side_t           side_o
);

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rest_q [ROOT_W];
  q2e_side_t         side_q [ROOT_W];
  logic              vld_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0]  rem_p, rem_sh, trial, rem_n;
    logic [ROOT_W-1:0] root_p;
    logic [RAD_W-1:0]  rest_p;
    q2e_side_t         side_p;
    logic              vld_p, ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rest_p = rad_i;
      assign side_p = side_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rest_p = rest_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_p[REM_W-3:0], rest_p[RAD_W-1 -: 2]};
      trial  = {(REM_W - ROOT_W - 2)'(0), root_p, 2'b01};
      ge     = (rem_sh >= trial);
      rem_n  = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_n;
        root_q[k] <= {root_p[ROOT_W-2:0], ge};
        rest_q[k] <= rest_p << 2;
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

// ===== rtl/q2e_cordic.sv =====
// three-lane pipelined cordic atan2: quadrant fold, normalizing shift, vectoring stages
module q2e_cordic import q2e_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [CIN_W-1:0] y_i [LANES],
  input  logic signed [CIN_W-1:0] x_i [LANES],
  input  q2e_flags_t              flags_i,
  output logic                    valid_o,
  output logic signed [ZW-1:0]    z_o [LANES],
  output q2e_flags_t              flags_o
);

  logic       vld_q [NSTG];
  q2e_flags_t flg_q [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_ctl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= (s == 0) ? valid_i : vld_q[(s == 0) ? 0 : s - 1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flg_q[s] <= (s == 0) ? flags_i : flg_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [XW-1:0] x_q   [NSTG];
    logic signed [XW-1:0] y_q   [NSTG];
    logic signed [ZW-1:0] z_q   [NSTG];
    logic                 fix_q [NSTG];
    logic [MW-1:0]        m_q   [PRE_STEPS+1];

    // entry: axis cases and fold into the right half plane
    logic signed [XW-1:0] xs, ys, x1, y1, ay;
    logic signed [ZW-1:0] fixz, zi;
    logic                 yz, xz, xn;

    always_comb begin
      xs   = XW'(x_i[l]);
      ys   = XW'(y_i[l]);
      yz   = (ys == 0);
      xz   = (xs == 0);
      xn   = (xs < 0);
      fixz = yz ? (xn ? DEG180 : ZW'(0)) : ((ys > 0) ? DEG90 : -DEG90);
      zi   = xn ? ((ys > 0) ? DEG180 : -DEG180) : ZW'(0);
      x1   = xn ? -xs : xs;
      y1   = xn ? -ys : ys;
      ay   = (y1 < 0) ? -y1 : y1;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[0]   <= x1;
        y_q[0]   <= y1;
        z_q[0]   <= (yz || xz) ? fixz : zi;
        fix_q[0] <= yz || xz;
        m_q[0]   <= MW'(x1 | ay);
      end
    end

    // normalize so the larger magnitude lands at bit NORM_MSB
    for (genvar j = 1; j <= PRE_STEPS; j++) begin : g_pre
      localparam int SH = 1 << (PRE_STEPS - j);
      logic do_sh;
      assign do_sh = ((m_q[j-1] >> (NORM_MSB + 1 - SH)) == '0);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[j]   <= do_sh ? (x_q[j-1] <<< SH) : x_q[j-1];
          y_q[j]   <= do_sh ? (y_q[j-1] <<< SH) : y_q[j-1];
          m_q[j]   <= do_sh ? (m_q[j-1] << SH) : m_q[j-1];
          z_q[j]   <= z_q[j-1];
          fix_q[j] <= fix_q[j-1];
        end
      end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      localparam int S = PRE_STEPS + 1 + i;
      logic signed [XW-1:0] dx, dy;
      logic                 pos;
      assign dx  = y_q[S-1] >>> i;
      assign dy  = x_q[S-1] >>> i;
      assign pos = (y_q[S-1] > 0);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[S]   <= pos ? (x_q[S-1] + dx) : (x_q[S-1] - dx);
          y_q[S]   <= pos ? (y_q[S-1] - dy) : (y_q[S-1] + dy);
          // axis cases keep their fixed angle
          z_q[S]   <= fix_q[S-1] ? z_q[S-1] :
                      (pos ? (z_q[S-1] + ATAN_TAB[i]) : (z_q[S-1] - ATAN_TAB[i]));
          fix_q[S] <= fix_q[S-1];
        end
      end
    end

    assign z_o[l] = z_q[NSTG-1];
  end

  assign valid_o = vld_q[NSTG-1];
  assign flags_o = flg_q[NSTG-1];

endmodule

// ===== rtl/q2e_checker.sv =====
// port-level checks of the quaternion to euler converter and their binding
module q2e_checker import q2e_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input q2e_out_t         out_data_o
);

  localparam logic signed [PITCH_W-1:0] P90 = PITCH_W'(LIM_PITCH);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.pitch_deg == '0 && out_data_o.yaw_deg == '0 &&
      out_data_o.roll_deg == '0 && !out_data_o.gimbal_clamped)
    else $error("degenerate result with nonzero angles");

  a_gimbal_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.gimbal_clamped |->
      out_data_o.pitch_deg == P90 || out_data_o.pitch_deg == -P90)
    else $error("clamped pitch not at ninety degrees");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.pitch_deg <= P90 && out_data_o.pitch_deg >= -P90)
    else $error("pitch out of range");

endmodule

bind quaternion_to_euler_core q2e_checker u_q2e_checker (.*);
